[rtl/msmq_pkg.sv]
// ----------------------------------------------------------------------------
// msmq_pkg
// shared types and constants of the masked share multiplier mod q
// ----------------------------------------------------------------------------
package msmq_pkg;

	localparam int MAX_SHARES = 8;
	localparam int IDX_W      = $clog2(MAX_SHARES);
	localparam int CNT_W      = $clog2(MAX_SHARES + 1);

	localparam logic [31:0] MODULUS_RESET     = 32'd8380417;
	localparam logic [3:0]  SHARE_COUNT_RESET = 4'd2;

	// configuration register indexes
	localparam logic REG_MODULUS     = 1'b0;
	localparam logic REG_SHARE_COUNT = 1'b1;

	// input item kinds
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_RANDOM = 1'b1;

	// remainder unit step counts
	localparam logic [6:0] STEPS_WIDE   = 7'd64;
	localparam logic [6:0] STEPS_NARROW = 7'd32;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LMUL,
		S_RED,
		S_LWR,
		S_RSAVE,
		S_P1MUL,
		S_P1SAVE,
		S_P2MUL,
		S_P2SAVE,
		S_ACCCALC,
		S_WRI,
		S_WRJ,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_LOAD,
		PH_RAND,
		PH_P1,
		PH_P2
	} phase_t;

endpackage

[rtl/masked_share_multiply_mod_q_unit.sv]
// ----------------------------------------------------------------------------
// masked_share_multiply_mod_q_unit
// masked product of two share vectors modulo a configurable q
// ----------------------------------------------------------------------------
// A run takes share_count load transactions (kind 0), then
// share_count*(share_count-1)/2 random transactions (kind 1) in pair order,
// and then drives share_count product shares on consecutive cycles, one per
// cycle marked by strobe, the final one with last. The receiver cannot stall:
// every strobe cycle is a delivered share. A transaction is taken when start
// is high and busy is low; a transaction of the wrong kind is dropped.
// Busy stays high while a load or a random word is processed and through
// emission, which reads one accumulator per cycle. The processing time
// comes from the bit-serial remainder unit, which resolves one bit per
// cycle: 64 steps for each full-width product and 32 for the random word.
// Shares, b shares and accumulators live in small synchronous memories
// with a registered read. Any configuration write restarts the run; write
// configuration only while busy is low.
module masked_share_multiply_mod_q_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [31:0] share_a,
	input  logic [31:0] share_b,
	input  logic [31:0] random_word,
	output logic        strobe,
	output logic [2:0]  share_index,
	output logic [31:0] product_share,
	output logic        last,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	// reduce a value below 2q to below q, zero for a degenerate modulus
	function automatic logic [31:0] modsub(input logic [32:0] v, input logic [31:0] q);
		logic [32:0] qx;
		qx = {1'b0, q};
		if (q < 32'd2) begin
			return 32'd0;
		end else if (v >= qx) begin
			return 32'(v - qx);
		end else begin
			return 32'(v);
		end
	endfunction

	// configuration
	logic [31:0] modulus_q;
	logic [3:0]  sc_q;

	// run control
	msmq_pkg::state_t state_q, state_d;
	msmq_pkg::phase_t ph_q;
	logic [msmq_pkg::CNT_W-1:0] lc_q;
	logic [msmq_pkg::IDX_W-1:0] pf_q, ps_q, k_q;
	logic [msmq_pkg::CNT_W-1:0] n_c;

	// remainder unit
	logic [63:0] md_val_q;
	logic [31:0] md_rem_q;
	logic [6:0]  md_cnt_q;
	logic [32:0] md_t;
	logic [31:0] md_next;
	logic [31:0] red_res;

	// datapath
	logic [31:0] a_in_q, b_in_q;
	logic [31:0] r_q, p1_q, p2_q, x_q, cross_q, ai_q;

	// memories
	logic [31:0] a_mem [msmq_pkg::MAX_SHARES];
	logic [31:0] b_mem [msmq_pkg::MAX_SHARES];
	logic [31:0] acc_mem [msmq_pkg::MAX_SHARES];
	logic [31:0] a_rd_q, b_rd_q, acc_rd_i_q, acc_rd_j_q;
	logic        ab_we, ab_re, acc_we, acc_re;
	logic [msmq_pkg::IDX_W-1:0] a_raddr, b_raddr, acc_waddr, acc_raddr_i, acc_raddr_j;
	logic [31:0] acc_wdata;

	// emission stage
	logic                       strobe_s1, last_s1;
	logic [msmq_pkg::IDX_W-1:0] idx_s1;

	logic accept, take_load, take_rand;
	logic [msmq_pkg::CNT_W-1:0] ps_inc, pf_inc, ps_wrap;
	logic pair_wrap, run_done;

	assign busy          = (state_q != msmq_pkg::S_IDLE);
	assign accept        = start && !busy;
	assign strobe        = strobe_s1;
	assign last          = last_s1;
	assign share_index   = 3'(idx_s1);
	assign product_share = acc_rd_i_q;

	// shares in use, clamped to the supported range
	always_comb begin
		if (sc_q == 4'd0) begin
			n_c = msmq_pkg::CNT_W'(1);
		end else if (32'(sc_q) > msmq_pkg::MAX_SHARES) begin
			n_c = msmq_pkg::CNT_W'(msmq_pkg::MAX_SHARES);
		end else begin
			n_c = msmq_pkg::CNT_W'(sc_q);
		end
	end

	// loads are due until lc reaches n, then random words
	assign take_load = accept && (lc_q < n_c) && (kind == msmq_pkg::KIND_LOAD);
	assign take_rand = accept && (lc_q >= n_c) && (kind == msmq_pkg::KIND_RANDOM)
		&& (n_c >= msmq_pkg::CNT_W'(2))
		&& (msmq_pkg::CNT_W'(pf_q) < n_c) && (msmq_pkg::CNT_W'(ps_q) < n_c);

	// pair order advance
	assign ps_inc    = msmq_pkg::CNT_W'(ps_q) + msmq_pkg::CNT_W'(1);
	assign pf_inc    = msmq_pkg::CNT_W'(pf_q) + msmq_pkg::CNT_W'(1);
	assign ps_wrap   = msmq_pkg::CNT_W'(pf_q) + msmq_pkg::CNT_W'(2);
	assign pair_wrap = (ps_inc >= n_c);
	assign run_done  = pair_wrap && (ps_wrap >= n_c);

	// one bit of restoring remainder per cycle
	assign md_t    = {md_rem_q, md_val_q[63]};
	assign md_next = (md_t >= {1'b0, modulus_q}) ? 32'(md_t - {1'b0, modulus_q}) : 32'(md_t);
	assign red_res = (modulus_q < 32'd2) ? 32'd0 : md_rem_q;

	// next state and memory controls
	always_comb begin
		state_d     = state_q;
		ab_we       = 1'b0;
		ab_re       = 1'b0;
		a_raddr     = pf_q;
		b_raddr     = ps_q;
		acc_we      = 1'b0;
		acc_waddr   = pf_q;
		acc_wdata   = ai_q;
		acc_re      = 1'b0;
		acc_raddr_i = pf_q;
		acc_raddr_j = ps_q;
		case (state_q)
			msmq_pkg::S_IDLE: begin
				if (take_load) begin
					ab_we   = 1'b1;
					state_d = msmq_pkg::S_LMUL;
				end else if (take_rand) begin
					state_d = msmq_pkg::S_RED;
				end
			end
			msmq_pkg::S_LMUL: begin
				state_d = msmq_pkg::S_RED;
			end
			msmq_pkg::S_RED: begin
				if (md_cnt_q == 7'd1) begin
					case (ph_q)
						msmq_pkg::PH_LOAD: state_d = msmq_pkg::S_LWR;
						msmq_pkg::PH_RAND: state_d = msmq_pkg::S_RSAVE;
						msmq_pkg::PH_P1:   state_d = msmq_pkg::S_P1SAVE;
						msmq_pkg::PH_P2:   state_d = msmq_pkg::S_P2SAVE;
						default:           state_d = msmq_pkg::S_IDLE;
					endcase
				end
			end
			msmq_pkg::S_LWR: begin
				acc_we    = 1'b1;
				acc_waddr = msmq_pkg::IDX_W'(lc_q);
				acc_wdata = red_res;
				if (n_c == msmq_pkg::CNT_W'(1)) begin
					state_d = msmq_pkg::S_EMIT;
				end else begin
					state_d = msmq_pkg::S_IDLE;
				end
			end
			msmq_pkg::S_RSAVE: begin
				// a_i and b_j
				ab_re   = 1'b1;
				state_d = msmq_pkg::S_P1MUL;
			end
			msmq_pkg::S_P1MUL: begin
				// a_j and b_i
				ab_re   = 1'b1;
				a_raddr = ps_q;
				b_raddr = pf_q;
				state_d = msmq_pkg::S_RED;
			end
			msmq_pkg::S_P1SAVE: begin
				state_d = msmq_pkg::S_P2MUL;
			end
			msmq_pkg::S_P2MUL: begin
				state_d = msmq_pkg::S_RED;
			end
			msmq_pkg::S_P2SAVE: begin
				acc_re  = 1'b1;
				state_d = msmq_pkg::S_ACCCALC;
			end
			msmq_pkg::S_ACCCALC: begin
				state_d = msmq_pkg::S_WRI;
			end
			msmq_pkg::S_WRI: begin
				acc_we    = 1'b1;
				acc_waddr = pf_q;
				acc_wdata = ai_q;
				state_d   = msmq_pkg::S_WRJ;
			end
			msmq_pkg::S_WRJ: begin
				acc_we    = 1'b1;
				acc_waddr = ps_q;
				acc_wdata = modsub({1'b0, acc_rd_j_q} + {1'b0, cross_q}, modulus_q);
				if (run_done) begin
					state_d = msmq_pkg::S_EMIT;
				end else begin
					state_d = msmq_pkg::S_IDLE;
				end
			end
			msmq_pkg::S_EMIT: begin
				acc_re      = 1'b1;
				acc_raddr_i = k_q;
				if (msmq_pkg::CNT_W'(k_q) == n_c - msmq_pkg::CNT_W'(1)) begin
					state_d = msmq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = msmq_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= msmq_pkg::S_IDLE;
			ph_q      <= msmq_pkg::PH_LOAD;
			modulus_q <= msmq_pkg::MODULUS_RESET;
			sc_q      <= msmq_pkg::SHARE_COUNT_RESET;
			lc_q      <= '0;
			pf_q      <= '0;
			ps_q      <= msmq_pkg::IDX_W'(1);
			k_q       <= '0;
			md_cnt_q  <= '0;
			strobe_s1 <= 1'b0;
			last_s1   <= 1'b0;
			idx_s1    <= '0;
		end else begin
			state_q   <= state_d;
			strobe_s1 <= 1'b0;
			last_s1   <= 1'b0;
			if (cfg_we) begin
				// any register write restarts the run
				case (cfg_index)
					msmq_pkg::REG_MODULUS:     modulus_q <= cfg_data;
					msmq_pkg::REG_SHARE_COUNT: sc_q      <= cfg_data[3:0];
					default:                   sc_q      <= sc_q;
				endcase
				lc_q <= '0;
				pf_q <= '0;
				ps_q <= msmq_pkg::IDX_W'(1);
			end
			case (state_q)
				msmq_pkg::S_IDLE: begin
					if (take_rand) begin
						ph_q     <= msmq_pkg::PH_RAND;
						md_cnt_q <= msmq_pkg::STEPS_NARROW;
					end
				end
				msmq_pkg::S_LMUL: begin
					ph_q     <= msmq_pkg::PH_LOAD;
					md_cnt_q <= msmq_pkg::STEPS_WIDE;
				end
				msmq_pkg::S_P1MUL: begin
					ph_q     <= msmq_pkg::PH_P1;
					md_cnt_q <= msmq_pkg::STEPS_WIDE;
				end
				msmq_pkg::S_P2MUL: begin
					ph_q     <= msmq_pkg::PH_P2;
					md_cnt_q <= msmq_pkg::STEPS_WIDE;
				end
				msmq_pkg::S_RED: begin
					md_cnt_q <= md_cnt_q - 7'd1;
				end
				msmq_pkg::S_LWR: begin
					lc_q <= lc_q + msmq_pkg::CNT_W'(1);
					k_q  <= '0;
				end
				msmq_pkg::S_WRJ: begin
					k_q <= '0;
					if (pair_wrap) begin
						pf_q <= msmq_pkg::IDX_W'(pf_inc);
						ps_q <= msmq_pkg::IDX_W'(ps_wrap);
					end else begin
						ps_q <= msmq_pkg::IDX_W'(ps_inc);
					end
				end
				msmq_pkg::S_EMIT: begin
					strobe_s1 <= 1'b1;
					idx_s1    <= k_q;
					if (msmq_pkg::CNT_W'(k_q) == n_c - msmq_pkg::CNT_W'(1)) begin
						// end of run, start over at the first load
						last_s1 <= 1'b1;
						lc_q    <= '0;
						pf_q    <= '0;
						ps_q    <= msmq_pkg::IDX_W'(1);
					end else begin
						k_q <= k_q + msmq_pkg::IDX_W'(1);
					end
				end
				default: begin
					ph_q <= ph_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			msmq_pkg::S_IDLE: begin
				a_in_q <= share_a;
				b_in_q <= share_b;
				if (take_rand) begin
					md_val_q <= {random_word, 32'd0};
					md_rem_q <= '0;
				end
			end
			msmq_pkg::S_LMUL: begin
				md_val_q <= 64'(a_in_q) * 64'(b_in_q);
				md_rem_q <= '0;
			end
			msmq_pkg::S_P1MUL, msmq_pkg::S_P2MUL: begin
				md_val_q <= 64'(a_rd_q) * 64'(b_rd_q);
				md_rem_q <= '0;
			end
			msmq_pkg::S_RED: begin
				md_val_q <= {md_val_q[62:0], 1'b0};
				md_rem_q <= md_next;
			end
			msmq_pkg::S_RSAVE: begin
				r_q <= red_res;
			end
			msmq_pkg::S_P1SAVE: begin
				p1_q <= red_res;
			end
			msmq_pkg::S_P2SAVE: begin
				p2_q <= red_res;
				x_q  <= modsub({1'b0, r_q} + {1'b0, p1_q}, modulus_q);
			end
			msmq_pkg::S_ACCCALC: begin
				cross_q <= modsub({1'b0, x_q} + {1'b0, p2_q}, modulus_q);
				ai_q    <= modsub({1'b0, acc_rd_i_q} + {1'b0, modulus_q} - {1'b0, r_q},
					modulus_q);
			end
			default: begin
				r_q <= r_q;
			end
		endcase
	end

	// share and accumulator memories
	always_ff @(posedge clk) begin
		if (ab_we) begin
			a_mem[msmq_pkg::IDX_W'(lc_q)] <= share_a;
			b_mem[msmq_pkg::IDX_W'(lc_q)] <= share_b;
		end
		if (ab_re) begin
			a_rd_q <= a_mem[a_raddr];
			b_rd_q <= b_mem[b_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
		if (acc_re) begin
			acc_rd_i_q <= acc_mem[acc_raddr_i];
			acc_rd_j_q <= acc_mem[acc_raddr_j];
		end
	end

`ifndef SYNTHESIS
	a_emit_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("emission broke off before the last share");

	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("share emitted after the last one");

	a_share_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (modulus_q < 32'd2) || (product_share < modulus_q))
		else $error("product share not reduced");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !strobe)
		else $error("share emitted right after a transaction was taken");
`endif

endmodule
